// ----- design/rotated_tile_blit_color_key_assert.svh -----
// Assertion macros for the rotated tile blit checker.
`ifndef ROTATED_TILE_BLIT_COLOR_KEY_ASSERT_SVH
`define ROTATED_TILE_BLIT_COLOR_KEY_ASSERT_SVH

// Check a consequence in the same cycle.
`define RTBCK_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the next cycle.
`define RTBCK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/rtbck_pkg.sv -----
package rtbck_pkg;

    localparam int TILE        = 16;
    localparam int HALF        = TILE / 2;
    localparam int FRAC_BITS   = 14;
    localparam int STORE_DEPTH = 256;
    localparam int ADDR_W      = 8;
    localparam int DATA_W      = 32;
    localparam int POS_W       = 4;
    localparam int BASE_W      = 10;
    localparam int COORD_OUT_W = 11;
    localparam int COEF_W      = 16;
    localparam int DELTA_W     = 6;
    localparam int PROD_W      = COEF_W + DELTA_W;
    localparam int SUM_W       = 24;
    localparam int COORD_W     = $clog2(TILE);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int CFG_IDX_W   = 1;

    localparam logic [DATA_W-1:0]        COLOR_KEY = 32'hFF00_0000;
    localparam logic signed [COEF_W-1:0] COS_RESET = 16'sd16384;
    localparam logic signed [COEF_W-1:0] SIN_RESET = 16'sd0;

    typedef enum logic
    {
        REQ_LOAD   = 1'b0,
        REQ_RENDER = 1'b1
    } req_kind_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        CFG_ROTATION_COS = 1'b0,
        CFG_ROTATION_SIN = 1'b1
    } cfg_index_t;

    typedef struct packed
    {
        logic                       is_load;
        logic [ADDR_W-1:0]          load_index;
        logic [DATA_W-1:0]          texel;
        logic signed [PROD_W-1:0]   cos_di;
        logic signed [PROD_W-1:0]   sin_dj;
        logic signed [PROD_W-1:0]   sin_di;
        logic signed [PROD_W-1:0]   cos_dj;
        logic [COORD_OUT_W-1:0]     out_x;
        logic [COORD_OUT_W-1:0]     out_y;
    } entry_t;

    typedef struct packed
    {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ----- design/rtbck_req_if.sv -----
interface rtbck_req_if
    import rtbck_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [ADDR_W-1:0] load_index;
    logic [DATA_W-1:0] texel_value;
    logic [POS_W-1:0]  pos_i;
    logic [POS_W-1:0]  pos_j;
    logic [BASE_W-1:0] base_x;
    logic [BASE_W-1:0] base_y;

    modport source
    (
        output valid, req_type, load_index, texel_value, pos_i, pos_j, base_x, base_y,
        input  ready
    );

    modport sink
    (
        input  valid, req_type, load_index, texel_value, pos_i, pos_j, base_x, base_y,
        output ready
    );
endinterface

// ----- design/rtbck_res_if.sv -----
interface rtbck_res_if
    import rtbck_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic                   write_pixel;
    logic [COORD_OUT_W-1:0] out_x;
    logic [COORD_OUT_W-1:0] out_y;
    logic [DATA_W-1:0]      out_color;

    modport source
    (
        output valid, write_pixel, out_x, out_y, out_color,
        input  ready
    );

    modport sink
    (
        input  valid, write_pixel, out_x, out_y, out_color,
        output ready
    );
endinterface

// ----- design/rtbck_front.sv -----
module rtbck_front
    import rtbck_pkg::*;
(
    rtbck_req_if.sink                   req,
    input  logic signed [COEF_W-1:0]    rotation_cos,
    input  logic signed [COEF_W-1:0]    rotation_sin,
    input  queue_status_t               status,
    output logic                        push,
    output entry_t                      entry
);

    logic signed [DELTA_W-1:0] di;
    logic signed [DELTA_W-1:0] dj;

    assign req.ready = !status.full;
    assign push      = req.valid && !status.full;

    always_comb
    begin
        di = $signed(DELTA_W'(req.pos_i)) - $signed(DELTA_W'(HALF));
        dj = $signed(DELTA_W'(req.pos_j)) - $signed(DELTA_W'(HALF));

        entry.is_load    = (req.req_type == REQ_LOAD);
        entry.load_index = req.load_index;
        entry.texel      = req.texel_value;
        entry.cos_di     = PROD_W'(rotation_cos) * PROD_W'(di);
        entry.sin_dj     = PROD_W'(rotation_sin) * PROD_W'(dj);
        entry.sin_di     = PROD_W'(rotation_sin) * PROD_W'(di);
        entry.cos_dj     = PROD_W'(rotation_cos) * PROD_W'(dj);
        entry.out_x      = COORD_OUT_W'(req.base_x) + COORD_OUT_W'(req.pos_i);
        entry.out_y      = COORD_OUT_W'(req.base_y) + COORD_OUT_W'(req.pos_j);
    end

endmodule

// ----- design/rtbck_queue.sv -----
module rtbck_queue
    import rtbck_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  entry_t          push_entry,
    input  logic            pop,
    output entry_t          head,
    output queue_status_t   status
);

    entry_t              entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;
    logic [QPTR_W:0]     count_next;
    logic                do_push;
    logic                do_pop;

    assign status.full  = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = entries_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ----- design/rtbck_back.sv -----
module rtbck_back
    import rtbck_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  entry_t          head,
    input  queue_status_t   status,
    output logic            pop,
    rtbck_res_if.source     res
);

    localparam logic signed [SUM_W-1:0] CENTER = SUM_W'(HALF * (2 ** FRAC_BITS));
    localparam logic signed [SUM_W-1:0] LIMIT  = SUM_W'(TILE * (2 ** FRAC_BITS));

    logic                       adv;
    logic signed [SUM_W-1:0]    sx;
    logic signed [SUM_W-1:0]    sy;
    logic [COORD_W-1:0]         col;
    logic [COORD_W-1:0]         row;
    logic                       inside_next;
    logic [ADDR_W-1:0]          addr_next;
    logic                       draw;

    logic                       s1_valid_reg;
    logic                       s1_load_reg;
    logic                       s1_inside_reg;
    logic [ADDR_W-1:0]          s1_addr_reg;
    logic [DATA_W-1:0]          s1_texel_reg;
    logic [COORD_OUT_W-1:0]     s1_x_reg;
    logic [COORD_OUT_W-1:0]     s1_y_reg;

    logic                       s2_valid_reg;
    logic                       s2_inside_reg;
    logic [COORD_OUT_W-1:0]     s2_x_reg;
    logic [COORD_OUT_W-1:0]     s2_y_reg;
    logic [DATA_W-1:0]          rd_data_reg;

    logic                       out_valid_reg;
    logic                       write_pixel_reg;
    logic [COORD_OUT_W-1:0]     out_x_reg;
    logic [COORD_OUT_W-1:0]     out_y_reg;
    logic [DATA_W-1:0]          out_color_reg;

    logic [DATA_W-1:0]          store_mem [STORE_DEPTH];

    assign adv = !out_valid_reg || res.ready;
    assign pop = adv && !status.empty;

    always_comb
    begin
        sx = SUM_W'(head.cos_di) - SUM_W'(head.sin_dj) + CENTER;
        sy = SUM_W'(head.sin_di) + SUM_W'(head.cos_dj) + CENTER;
        inside_next = !sx[SUM_W-1] && (sx < LIMIT) && !sy[SUM_W-1] && (sy < LIMIT);
        col = sx[FRAC_BITS +: COORD_W];
        row = sy[FRAC_BITS +: COORD_W];
        if (head.is_load)
        begin
            addr_next = head.load_index;
        end
        else
        begin
            addr_next = ADDR_W'(ADDR_W'(row) * ADDR_W'(TILE) + ADDR_W'(col));
        end
        draw = s2_inside_reg && (rd_data_reg != COLOR_KEY);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= !status.empty;
            s2_valid_reg  <= s1_valid_reg && !s1_load_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_load_reg     <= head.is_load;
            s1_inside_reg   <= inside_next;
            s1_addr_reg     <= addr_next;
            s1_texel_reg    <= head.texel;
            s1_x_reg        <= head.out_x;
            s1_y_reg        <= head.out_y;

            s2_inside_reg   <= s1_inside_reg;
            s2_x_reg        <= s1_x_reg;
            s2_y_reg        <= s1_y_reg;

            write_pixel_reg <= draw;
            out_x_reg       <= s2_x_reg;
            out_y_reg       <= s2_y_reg;
            out_color_reg   <= draw ? rd_data_reg : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s1_valid_reg && s1_load_reg)
        begin
            store_mem[s1_addr_reg] <= s1_texel_reg;
        end
        if (adv)
        begin
            rd_data_reg <= store_mem[s1_addr_reg];
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.write_pixel = write_pixel_reg;
    assign res.out_x       = out_x_reg;
    assign res.out_y       = out_y_reg;
    assign res.out_color   = out_color_reg;

endmodule

// ----- design/rotated_tile_blit_color_key.sv -----
// Rotated tile blit with a color key. Load requests fill a 256-entry tile store; render
// requests rotate a destination pixel about the tile center by the cos/sin registers
// (signed Q2.14), look up the source texel and emit one result each, with write_pixel
// low when the source falls outside the tile or hits the key 0xFF000000. One request is
// taken per clock while the queue is not full; a render result passes through the queue
// and the s1, s2 and output registers; loads give no result. The single-port tile store
// serves one load or one lookup per cycle, which sets the rate at one request per clock.
// A four-entry request queue lets the input keep flowing while results are held.
// Write the rotation registers only while no request is in flight.
module rotated_tile_blit_color_key
    import rtbck_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [COEF_W-1:0]       cfg_data,
    rtbck_req_if.sink               req,
    rtbck_res_if.source             res
);

    logic signed [COEF_W-1:0] rotation_cos_reg;
    logic signed [COEF_W-1:0] rotation_sin_reg;
    queue_status_t            status;
    entry_t                   push_entry;
    entry_t                   head;
    logic                     push;
    logic                     pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotation_cos_reg <= COS_RESET;
            rotation_sin_reg <= SIN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_ROTATION_COS: rotation_cos_reg <= cfg_data;
                CFG_ROTATION_SIN: rotation_sin_reg <= cfg_data;
            endcase
        end
    end

    rtbck_front u_front
    (
        .req          (req),
        .rotation_cos (rotation_cos_reg),
        .rotation_sin (rotation_sin_reg),
        .status       (status),
        .push         (push),
        .entry        (push_entry)
    );

    rtbck_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (status)
    );

    rtbck_back u_back
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .status (status),
        .pop    (pop),
        .res    (res)
    );

endmodule

// ----- design/rtbck_checker.sv -----
`include "rotated_tile_blit_color_key_assert.svh"

module rtbck_checker
    import rtbck_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     res_valid,
    input logic                     res_ready,
    input logic                     res_write_pixel,
    input logic [COORD_OUT_W-1:0]   res_out_x,
    input logic [COORD_OUT_W-1:0]   res_out_y,
    input logic [DATA_W-1:0]        res_out_color
);

    `RTBCK_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_write_pixel) && $stable(res_out_x) && $stable(res_out_y) && $stable(res_out_color), "stalled result changed")
    `RTBCK_ASSERT_NOW(a_blank_color, res_valid && !res_write_pixel, res_out_color == '0, "skipped pixel carries a color")
    `RTBCK_ASSERT_NOW(a_key_dropped, res_valid && res_write_pixel, res_out_color != COLOR_KEY, "key color written")

endmodule

bind rotated_tile_blit_color_key rtbck_checker u_rtbck_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (res.valid),
    .res_ready       (res.ready),
    .res_write_pixel (res.write_pixel),
    .res_out_x       (res.out_x),
    .res_out_y       (res.out_y),
    .res_out_color   (res.out_color)
);

// ----- sim/rotated_tile_blit_color_key_checker.sv -----
`timescale 1ns / 1ps

module rotated_tile_blit_color_key_checker
    import rtbck_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COEF_W-1:0]    cfg_data,
    rtbck_req_if                 req,
    rtbck_res_if                 res,
    output int                   fail_count,
    output int                   pending
);

    typedef struct packed
    {
        logic                   write_pixel;
        logic [COORD_OUT_W-1:0] out_x;
        logic [COORD_OUT_W-1:0] out_y;
        logic [DATA_W-1:0]      out_color;
    } pixel_t;

    logic [DATA_W-1:0]        texels [STORE_DEPTH];
    logic signed [COEF_W-1:0] rot_cos;
    logic signed [COEF_W-1:0] rot_sin;
    pixel_t                   expected_pixels [$];
    int                       mismatches;

    function automatic pixel_t blit_pixel
    (
        logic [POS_W-1:0]  pi,
        logic [POS_W-1:0]  pj,
        logic [BASE_W-1:0] bx,
        logic [BASE_W-1:0] by
    );
        longint            di;
        longint            dj;
        longint            c;
        longint            s;
        longint            sx;
        longint            sy;
        longint            lim;
        logic [DATA_W-1:0] texel;
        pixel_t            p;
        di = longint'(pi) - HALF;
        dj = longint'(pj) - HALF;
        c = longint'(rot_cos);
        s = longint'(rot_sin);
        sx = c * di - s * dj + (longint'(HALF) <<< FRAC_BITS);
        sy = s * di + c * dj + (longint'(HALF) <<< FRAC_BITS);
        lim = longint'(TILE) <<< FRAC_BITS;
        p.write_pixel = 1'b0;
        p.out_color = '0;
        p.out_x = COORD_OUT_W'(bx) + COORD_OUT_W'(pi);
        p.out_y = COORD_OUT_W'(by) + COORD_OUT_W'(pj);
        if (sx >= 0 && sx < lim && sy >= 0 && sy < lim)
        begin
            texel = texels[ADDR_W'((sy >>> FRAC_BITS) * TILE + (sx >>> FRAC_BITS))];
            if (texel != COLOR_KEY)
            begin
                p.write_pixel = 1'b1;
                p.out_color = texel;
            end
        end
        return p;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pixel_t want;
        if (!rst_n)
        begin
            rot_cos = COS_RESET;
            rot_sin = SIN_RESET;
            foreach (texels[a])
                texels[a] = '0;
            expected_pixels.delete();
            fail_count = 0;
            mismatches = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_ROTATION_COS)
                    rot_cos = cfg_data;
                else
                    rot_sin = cfg_data;
            end

            if (res.valid && res.ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    fail_count++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected pixel: write=%0b x=%0d y=%0d color=%h",
                                 res.write_pixel, res.out_x, res.out_y, res.out_color);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (res.write_pixel !== want.write_pixel || res.out_x !== want.out_x ||
                        res.out_y !== want.out_y || res.out_color !== want.out_color)
                    begin
                        fail_count++;
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $write("pixel mismatch: expected write=%0b x=%0d y=%0d color=%h, ",
                                   want.write_pixel, want.out_x, want.out_y,
                                   want.out_color);
                            $display("got write=%0b x=%0d y=%0d color=%h",
                                     res.write_pixel, res.out_x, res.out_y,
                                     res.out_color);
                        end
                    end
                end
            end

            if (req.valid && req.ready)
            begin
                if (req.req_type == REQ_LOAD)
                    texels[req.load_index] = req.texel_value;
                else
                    expected_pixels.push_back(blit_pixel(req.pos_i, req.pos_j,
                                                         req.base_x, req.base_y));
            end

            pending = expected_pixels.size();
        end
    end

endmodule

// ----- sim/rotated_tile_blit_color_key_tb.sv -----
`timescale 1ns / 1ps

module rotated_tile_blit_color_key_tb;
    import rtbck_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int PHASE_ITEMS    = 150;
    localparam int LOAD_PERCENT   = 15;
    localparam int READY_ALWAYS   = 0;
    localparam int READY_RANDOM   = 1;
    localparam int READY_PERIODIC = 2;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COEF_W-1:0]    cfg_data;
    int                   fail_count;
    int                   pending;
    int                   burst_left;
    int                   idle_cycles;
    int                   ready_mode;
    int                   ready_run;
    int                   phase_cos [6] = '{16384, -16384, 0, 0, 16384, -16384};
    int                   phase_sin [6] = '{0, 0, 16384, -16384, 16384, -16384};

    rtbck_req_if req();
    rtbck_res_if res();

    rotated_tile_blit_color_key uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .res       (res)
    );

    rotated_tile_blit_color_key_checker checker_inst
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req        (req),
        .res        (res),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        if (ready_run == 0)
        begin
            ready_mode = $urandom_range(0, 2);
            ready_run = $urandom_range(4, 40);
        end
        ready_run = ready_run - 1;
        case (ready_mode)
            READY_ALWAYS: res.ready = 1'b1;
            READY_RANDOM: res.ready = 1'($urandom_range(0, 1));
            default:      res.ready = (ready_run % 7) > 2;
        endcase
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req.valid && req.ready) || (res.valid && res.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [DATA_W-1:0] random_texel();
        return ($urandom_range(0, 3) == 0) ? COLOR_KEY : DATA_W'($urandom());
    endfunction

    task automatic send
    (
        req_kind_t         kind,
        logic [ADDR_W-1:0] idx,
        logic [DATA_W-1:0] texel,
        logic [POS_W-1:0]  pi,
        logic [POS_W-1:0]  pj,
        logic [BASE_W-1:0] bx,
        logic [BASE_W-1:0] by
    );
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                req.valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        req.valid = 1'b1;
        req.req_type = kind;
        req.load_index = idx;
        req.texel_value = texel;
        req.pos_i = pi;
        req.pos_j = pj;
        req.base_x = bx;
        req.base_y = by;
        // hold the request until it is taken
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        burst_left--;
        @(negedge clk);
    endtask

    task automatic load_texel(logic [ADDR_W-1:0] idx, logic [DATA_W-1:0] texel);
        send(REQ_LOAD, idx, texel, POS_W'($urandom()), POS_W'($urandom()),
             BASE_W'($urandom()), BASE_W'($urandom()));
    endtask

    task automatic render
    (
        logic [POS_W-1:0]  pi,
        logic [POS_W-1:0]  pj,
        logic [BASE_W-1:0] bx,
        logic [BASE_W-1:0] by
    );
        send(REQ_RENDER, ADDR_W'($urandom()), DATA_W'($urandom()), pi, pj, bx, by);
    endtask

    task automatic drain();
        req.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_rotation(logic [COEF_W-1:0] c, logic [COEF_W-1:0] s);
        drain();
        cfg_we = 1'b1;
        cfg_index = CFG_ROTATION_COS;
        cfg_data = c;
        @(negedge clk);
        cfg_index = CFG_ROTATION_SIN;
        cfg_data = s;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic random_phase(int n);
        repeat (n)
        begin
            if ($urandom_range(0, 99) < LOAD_PERCENT)
                load_texel(ADDR_W'($urandom_range(0, STORE_DEPTH - 1)), random_texel());
            else
                render(POS_W'($urandom()), POS_W'($urandom()),
                       BASE_W'($urandom()), BASE_W'($urandom()));
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_ROTATION_COS;
        cfg_data = '0;
        req.valid = 1'b0;
        req.req_type = REQ_LOAD;
        req.load_index = '0;
        req.texel_value = '0;
        req.pos_i = '0;
        req.pos_j = '0;
        req.base_x = '0;
        req.base_y = '0;
        burst_left = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // fill every texel so no lookup ever hits an unwritten entry
        for (int a = 0; a < STORE_DEPTH; a++)
            load_texel(ADDR_W'(a), random_texel());

        load_texel(8'h00, COLOR_KEY);
        load_texel(8'hFF, 32'hFFFF_FFFF);
        load_texel(8'h88, 32'h0000_0000);
        load_texel(8'h0F, 32'hFF00_0001);
        render(4'd0, 4'd0, 10'd0, 10'd0);
        render(4'd15, 4'd15, 10'd1023, 10'd1023);
        render(4'd8, 4'd8, 10'd512, 10'd512);
        render(4'd15, 4'd0, 10'd1023, 10'd0);
        render(4'd0, 4'd15, 10'd0, 10'd1023);

        // 45 degrees: corners fall outside the tile
        set_rotation(16'sd11585, 16'sd11585);
        render(4'd0, 4'd0, 10'd100, 10'd200);
        render(4'd15, 4'd15, 10'd1023, 10'd0);
        render(4'd0, 4'd15, 10'd0, 10'd1023);
        render(4'd15, 4'd0, 10'd300, 10'd400);

        set_rotation(16'h8000, 16'h7FFF);
        render(4'd0, 4'd0, 10'd0, 10'd0);
        render(4'd15, 4'd15, 10'd1023, 10'd1023);

        set_rotation(16'sd0, -16'sd16384);
        render(4'd3, 4'd12, 10'd5, 10'd6);

        for (int p = 0; p < 6; p++)
        begin
            set_rotation(COEF_W'(phase_cos[p]), COEF_W'(phase_sin[p]));
            random_phase(PHASE_ITEMS);
        end
        repeat (3)
        begin
            set_rotation(COEF_W'(int'($urandom_range(0, 32768)) - 16384),
                         COEF_W'(int'($urandom_range(0, 32768)) - 16384));
            random_phase(PHASE_ITEMS);
        end
        set_rotation(COEF_W'($urandom()), COEF_W'($urandom()));
        random_phase(PHASE_ITEMS);

        drain();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
